// ----- src/page_sequence_word_framer_macros.svh -----
// Assertion macros for the page sequence word framer checker.
// Used by pswf_checker.sv; no other dependencies.
`ifndef PAGE_SEQUENCE_WORD_FRAMER_MACROS_SVH
`define PAGE_SEQUENCE_WORD_FRAMER_MACROS_SVH

// same-cycle implication
`define PSWF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pswf_pkg.sv -----
// Shared types and constants for the page sequence word framer.
// No dependencies; imported by page_sequence_word_framer and pswf_checker.
package pswf_pkg;

    localparam int unsigned PAGE_CHUNKS_DEF = 16;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned SLOT_W          = 4;
    localparam int unsigned DATA_PER_CHUNK  = 15;
    localparam int unsigned RAW_PER_CHUNK   = 16;
    localparam int unsigned LEAF_BIT        = 31;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        t_word data_out;
        logic  is_header;
        logic  last;
        logic  mismatch;
    } t_result;

endpackage

// ----- src/page_sequence_word_framer.sv -----
// Page sequence word framer: inserts or strips one sequence word per 16-word chunk.
// Depends on pswf_pkg.
//
// Input channel (i_valid / o_ready) takes one word per handshake: a page word in
// encode mode (i_cmd = 0) or a raw framed word in decode mode (i_cmd = 1). The
// first encode word of a page also carries i_old_seq and i_is_leaf.
// Output channel (o_valid / i_ready) delivers result words from a result register.
// Results are registered: a word's first result shows on o_valid the cycle after
// the word is taken. Throughput: one word per cycle while i_ready stays high,
// except that an encode word opening a chunk yields a header and a data word; the
// data word waits in a second register and input is held off until it empties.
// Decode chunk headers produce no result: the page's first one loads the sequence
// word; later ones are checked against it. Mismatch shows on the page's last word.
// Reset clears the counters, sequence word, mismatch flag and both result slots.
// When the receiver stalls, the result register holds and o_ready stays high only
// while the second register is empty and the result register can take a new word.
module page_sequence_word_framer #(
    parameter int unsigned PAGE_CHUNKS = pswf_pkg::PAGE_CHUNKS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_cmd,
    input  pswf_pkg::t_word         i_data_in,
    input  pswf_pkg::t_word         i_old_seq,
    input  logic                    i_is_leaf,
    output logic                    o_valid,
    input  logic                    i_ready,
    output pswf_pkg::t_word         o_data_out,
    output logic                    o_is_header,
    output logic                    o_last,
    output logic                    o_mismatch
);
    import pswf_pkg::*;

    localparam int unsigned CHUNK_W = (PAGE_CHUNKS > 1) ? $clog2(PAGE_CHUNKS) : 1;
    localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(PAGE_CHUNKS - 1);
    localparam t_slot ENC_SLOT_END = t_slot'(DATA_PER_CHUNK - 1);
    localparam t_slot DEC_SLOT_END = t_slot'(RAW_PER_CHUNK - 1);

    t_word               r_seq,   n_seq;
    t_slot               r_slot,  n_slot;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic                r_mm,    n_mm;

    logic                r_out_vld,  n_out_vld;
    t_result             r_out,      n_out;
    logic                r_pend_vld, n_pend_vld;
    t_result             r_pend,     n_pend;

    logic    accept;
    logic    out_take;
    logic    gen_hdr;
    logic    gen_dat;
    t_result res_hdr;
    t_result res_dat;
    t_word   seq_new;
    logic    chunk_end;

    assign out_take = r_out_vld && i_ready;
    assign o_ready  = !r_pend_vld && (!r_out_vld || i_ready);
    assign accept   = i_valid && o_ready;

    assign seq_new   = {i_is_leaf, i_old_seq[LEAF_BIT-1:0] + (LEAF_BIT)'(1)};
    assign chunk_end = (r_chunk == CHUNK_LAST);

    always_comb begin
        n_seq   = r_seq;
        n_slot  = r_slot;
        n_chunk = r_chunk;
        n_mm    = r_mm;
        gen_hdr = 1'b0;
        gen_dat = 1'b0;
        res_hdr = '{data_out: r_seq, is_header: 1'b1, last: 1'b0, mismatch: 1'b0};
        res_dat = '{data_out: i_data_in, is_header: 1'b0, last: 1'b0, mismatch: 1'b0};
        case (t_cmd'(i_cmd))
            CMD_ENCODE: begin
                gen_dat = 1'b1;
                if (r_slot == '0) begin
                    gen_hdr = 1'b1;
                    if (r_chunk == '0) begin
                        n_seq            = seq_new;
                        res_hdr.data_out = seq_new;
                    end
                end
                if (r_slot >= ENC_SLOT_END) begin
                    n_slot       = '0;
                    n_chunk      = chunk_end ? '0 : r_chunk + CHUNK_W'(1);
                    res_dat.last = chunk_end;
                end else begin
                    n_slot = r_slot + t_slot'(1);
                end
            end
            CMD_DECODE: begin
                if (r_slot == '0) begin
                    if (r_chunk == '0) begin
                        n_seq = i_data_in;
                        n_mm  = 1'b0;
                    end else if (i_data_in != r_seq) begin
                        n_mm = 1'b1;
                    end
                    n_slot = t_slot'(1);
                end else begin
                    gen_dat = 1'b1;
                    if (r_slot == DEC_SLOT_END) begin
                        n_slot           = '0;
                        n_chunk          = chunk_end ? '0 : r_chunk + CHUNK_W'(1);
                        res_dat.last     = chunk_end;
                        res_dat.mismatch = chunk_end && r_mm;
                    end else begin
                        n_slot = r_slot + t_slot'(1);
                    end
                end
            end
            default: begin
                gen_dat = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        if (r_pend_vld) begin
            if (out_take) begin
                n_out      = r_pend;
                n_pend_vld = 1'b0;
            end
        end else if (accept && gen_hdr) begin
            n_out_vld  = 1'b1;
            n_out      = res_hdr;
            n_pend_vld = 1'b1;
            n_pend     = res_dat;
        end else if (accept && gen_dat) begin
            n_out_vld = 1'b1;
            n_out     = res_dat;
        end else if (out_take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= '0;
            r_slot     <= '0;
            r_chunk    <= '0;
            r_mm       <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_seq   <= n_seq;
                r_slot  <= n_slot;
                r_chunk <= n_chunk;
                r_mm    <= n_mm;
            end
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_valid     = r_out_vld;
    assign o_data_out  = r_out.data_out;
    assign o_is_header = r_out.is_header;
    assign o_last      = r_out.last;
    assign o_mismatch  = r_out.mismatch;

endmodule

// ----- src/pswf_checker.sv -----
// Port-level checks for page_sequence_word_framer, attached by bind.
// Depends on pswf_pkg and page_sequence_word_framer_macros.svh.
`include "page_sequence_word_framer_macros.svh"

module pswf_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input pswf_pkg::t_word o_data_out,
    input logic            o_is_header,
    input logic            o_last,
    input logic            o_mismatch
);
    import pswf_pkg::*;

    `PSWF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data_out), "output word dropped or changed while stalled")
    `PSWF_ASSERT_NOW(a_mm_on_last, i_clk, i_rst_n, o_valid && o_mismatch, o_last && !o_is_header, "mismatch shown off the last word")
    `PSWF_ASSERT_NOW(a_hdr_not_last, i_clk, i_rst_n, o_valid && o_is_header, !o_last && !o_mismatch && !o_ready, "header word flagged last or mismatch, or input open")
    `PSWF_ASSERT_NEXT(a_hdr_then_data, i_clk, i_rst_n, o_valid && i_ready && o_is_header, o_valid && !o_is_header, "header not followed by its data word")

endmodule

bind page_sequence_word_framer pswf_checker u_pswf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_data_out  (o_data_out),
    .o_is_header (o_is_header),
    .o_last      (o_last),
    .o_mismatch  (o_mismatch)
);
